// ===== hdl/msgtok_pkg.sv =====
// ----------------------------------------------------------------------------
// MessagePack tokenizer package
// Shared types, tag codes and decode helpers for the stream tokenizer.
// ----------------------------------------------------------------------------
package msgtok_pkg;

    localparam int MAX_NESTING_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 32;
    localparam int VALUE_W = 64;
    localparam int DEPTH_W = 5;
    localparam int REM_W   = 33;
    localparam int OPN_W   = 4;

    localparam logic [7:0] TAG_NIL     = 8'hc0;
    localparam logic [7:0] TAG_FALSE   = 8'hc2;
    localparam logic [7:0] TAG_TRUE    = 8'hc3;
    localparam logic [7:0] TAG_F32     = 8'hca;
    localparam logic [7:0] TAG_F64     = 8'hcb;
    localparam logic [7:0] TAG_U8      = 8'hcc;
    localparam logic [7:0] TAG_U16     = 8'hcd;
    localparam logic [7:0] TAG_U32     = 8'hce;
    localparam logic [7:0] TAG_U64     = 8'hcf;
    localparam logic [7:0] TAG_I8      = 8'hd0;
    localparam logic [7:0] TAG_I16     = 8'hd1;
    localparam logic [7:0] TAG_I32     = 8'hd2;
    localparam logic [7:0] TAG_I64     = 8'hd3;
    localparam logic [7:0] TAG_STR8    = 8'hd9;
    localparam logic [7:0] TAG_STR16   = 8'hda;
    localparam logic [7:0] TAG_STR32   = 8'hdb;
    localparam logic [7:0] TAG_ARR16   = 8'hdc;
    localparam logic [7:0] TAG_ARR32   = 8'hdd;
    localparam logic [7:0] TAG_MAP16   = 8'hde;
    localparam logic [7:0] TAG_MAP32   = 8'hdf;
    localparam logic [7:0] TAG_POSMAX  = 8'h7f;
    localparam logic [7:0] TAG_NEGMIN  = 8'he0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TAG,
        PH_OPER,
        PH_STR
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_POP,
        SQ_POPW,
        SQ_EMIT
    } seq_t;

    typedef enum logic [3:0] {
        TK_NIL     = 4'd0,
        TK_BOOL    = 4'd1,
        TK_UINT    = 4'd2,
        TK_INT     = 4'd3,
        TK_F32     = 4'd4,
        TK_F64     = 4'd5,
        TK_STRHDR  = 4'd6,
        TK_STRBYTE = 4'd7,
        TK_ARRAY   = 4'd8,
        TK_MAP     = 4'd9,
        TK_END     = 4'd10,
        TK_ERROR   = 4'd11
    } tkind_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_DEEP  = 3'd1,
        ERR_TRUNC = 3'd2,
        ERR_TAG   = 3'd3,
        ERR_LEN   = 3'd4,
        ERR_KEY   = 3'd5,
        ERR_TRAIL = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_VALUE,
        ACT_CONT,
        ACT_STR,
        ACT_FAIL,
        ACT_LOAD
    } act_code_t;

    typedef struct packed {
        tkind_t               kind;
        logic [VALUE_W-1:0]   value;
        logic [DEPTH_W-1:0]   depth;
        logic                 key;
        err_t                 err;
    } tok_t;

    typedef struct packed {
        act_code_t            code;
        tkind_t               kind;
        logic [VALUE_W-1:0]   value;
        logic                 is_map;
        logic [LEN_W-1:0]     len;
        err_t                 err;
        logic [OPN_W-1:0]     nbytes;
    } act_t;

    // Returns the operand byte count in the low bits and an unsupported flag on top.
    function automatic logic [OPN_W:0] operand_bytes(input logic [7:0] tag);
        logic [OPN_W:0] r;
        r = '0;
        if (tag > 8'hbf && tag < TAG_NEGMIN) begin
            case (tag) inside
                TAG_NIL, TAG_FALSE, TAG_TRUE:                           r = 5'd0;
                TAG_U8, TAG_I8, TAG_STR8:                               r = 5'd1;
                TAG_U16, TAG_I16, TAG_STR16, TAG_ARR16, TAG_MAP16:      r = 5'd2;
                TAG_F32, TAG_U32, TAG_I32, TAG_STR32, TAG_ARR32,
                TAG_MAP32:                                              r = 5'd4;
                TAG_F64, TAG_U64, TAG_I64:                              r = 5'd8;
                default:                                                r = 5'h10;
            endcase
        end
        return r;
    endfunction

    function automatic logic is_string_tag(input logic [7:0] tag);
        return (tag[7:5] == 3'b101) || tag == TAG_STR8 || tag == TAG_STR16
            || tag == TAG_STR32;
    endfunction

endpackage

// ===== hdl/msgpack_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// MessagePack stream tokenizer
// Parses one MessagePack body byte per word and emits value tokens, keeping
// the open containers on a stack held in a synchronous memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit first)                       tuser   tlast
//  s_       in         data_byte, body_length                      kind    -
//  m_       out        token_kind, token_value, token_depth,       -       last_of_run
//                      is_map_key, error_code
//
// A word is accepted in the idle state and parsed in the next cycle; a word without a
// token then returns to idle, and a string byte that leaves its string open passes
// through the emit state. A word that completes a value passes through the pop state
// before its one or two tokens are emitted. Each container closed by that value adds
// a stack memory read in the pop-wait state, the outermost one only another pop step.
// Reset clears the control state; the stack memory is not cleared. A stalled
// result channel holds the block after the parse cycle until the tokens drain.
// ----------------------------------------------------------------------------
module msgpack_stream_tokenizer #(
    parameter int MAX_NESTING = msgtok_pkg::MAX_NESTING_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte, body_length
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // token_kind, token_value, token_depth, is_map_key,
                                   // error_code, zero fill
    output logic        m_tlast
);

    localparam int LW = $clog2(MAX_NESTING + 1);
    localparam int SD = (MAX_NESTING < 2) ? 2 : MAX_NESTING;
    localparam int IW = $clog2(SD);
    localparam int RW = msgtok_pkg::REM_W;

    msgtok_pkg::seq_t   seq_reg, seq_next;
    msgtok_pkg::phase_t phase_reg, phase_next;
    logic [LW-1:0]      level_reg, level_next;
    logic [RW-1:0]      top_rem_reg, top_rem_next;
    logic               top_map_reg, top_map_next;
    logic [7:0]         tag_reg, tag_next;
    logic [63:0]        accum_reg, accum_next;
    logic [3:0]         left_reg, left_next;
    logic [31:0]        str_left_reg, str_left_next;
    logic [31:0]        body_left_reg, body_left_next;
    msgtok_pkg::tok_t   tok1_reg, tok1_next, tok2_reg, tok2_next;
    logic [1:0]         tcnt_reg, tcnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [79:0]        m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               in_kind_reg;
    logic [7:0]         in_byte_reg;
    logic [31:0]        in_len_reg;

    logic [RW:0]        stack_mem [SD];
    logic [RW:0]        rd_data_reg;
    logic               push_we;
    logic [IW-1:0]      wr_idx, rd_idx;

    msgtok_pkg::act_t   act;
    logic [31:0]        bl;
    logic [3:0]         left_dec;
    logic [63:0]        accum_shift;
    logic               key_pos;
    logic [RW-1:0]      pop_dec;
    logic               exec_complete, exec_have, pop_done, pop_to_read;
    logic               out_free;
    logic [msgtok_pkg::DEPTH_W-1:0] depth_now;

    assign s_tready = (seq_reg == msgtok_pkg::SQ_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign bl          = body_left_reg - 32'(body_left_reg != '0);
    assign left_dec    = left_reg - 4'(left_reg != '0);
    assign accum_shift = {accum_reg[55:0], in_byte_reg};
    assign key_pos     = (level_reg != '0) && top_map_reg && !top_rem_reg[0];
    assign pop_dec     = top_rem_reg - RW'(top_rem_reg != '0);
    assign depth_now   = msgtok_pkg::DEPTH_W'(level_reg);
    assign wr_idx      = IW'(level_reg - LW'(1));
    assign rd_idx      = IW'(level_reg - LW'(2));
    assign pop_done    = (level_reg == '0) || (pop_dec != '0);
    assign pop_to_read = (level_reg != LW'(1));

    msgtok_decode u_decode (
        .phase     (phase_reg),
        .data_byte (in_byte_reg),
        .tag_held  (tag_reg),
        .operand   (accum_shift),
        .body_rem  (bl),
        .key_pos   (key_pos),
        .act       (act)
    );

    // Parse datapath.
    always_comb begin
        phase_next     = phase_reg;
        level_next     = level_reg;
        top_rem_next   = top_rem_reg;
        top_map_next   = top_map_reg;
        tag_next       = tag_reg;
        accum_next     = accum_reg;
        left_next      = left_reg;
        str_left_next  = str_left_reg;
        body_left_next = body_left_reg;
        tok1_next      = tok1_reg;
        tok2_next      = tok2_reg;
        tcnt_next      = tcnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        push_we        = 1'b0;
        exec_complete  = 1'b0;
        exec_have      = 1'b0;

        case (seq_reg)
            msgtok_pkg::SQ_EXEC: begin
                tok1_next.kind  = msgtok_pkg::TK_ERROR;
                tok1_next.value = '0;
                tok1_next.depth = depth_now;
                tok1_next.key   = 1'b0;
                tok1_next.err   = msgtok_pkg::ERR_NONE;
                if (!in_kind_reg) begin
                    level_next     = '0;
                    body_left_next = in_len_reg;
                    str_left_next  = '0;
                    left_next      = '0;
                    accum_next     = '0;
                    tag_next       = '0;
                    if (in_len_reg == '0) begin
                        exec_have       = 1'b1;
                        tok1_next.depth = '0;
                        tok1_next.err   = msgtok_pkg::ERR_TRUNC;
                        phase_next      = msgtok_pkg::PH_IDLE;
                    end else begin
                        phase_next = msgtok_pkg::PH_TAG;
                    end
                end else if (phase_reg == msgtok_pkg::PH_STR) begin
                    body_left_next  = bl;
                    exec_have       = 1'b1;
                    tok1_next.kind  = msgtok_pkg::TK_STRBYTE;
                    tok1_next.value = {56'd0, in_byte_reg};
                    str_left_next   = str_left_reg - 32'(str_left_reg != '0);
                    exec_complete   = (str_left_next == '0);
                end else if (phase_reg == msgtok_pkg::PH_OPER && left_dec != '0) begin
                    body_left_next = bl;
                    accum_next     = accum_shift;
                    left_next      = left_dec;
                end else if (phase_reg != msgtok_pkg::PH_IDLE) begin
                    body_left_next = bl;
                    accum_next     = accum_shift;
                    left_next      = left_dec;
                    tok1_next.key  = key_pos;
                    case (act.code)
                        msgtok_pkg::ACT_FAIL: begin
                            exec_have     = 1'b1;
                            tok1_next.err = act.err;
                            tok1_next.key = 1'b0;
                            phase_next    = msgtok_pkg::PH_IDLE;
                        end
                        msgtok_pkg::ACT_LOAD: begin
                            tag_next   = in_byte_reg;
                            accum_next = '0;
                            left_next  = act.nbytes;
                            phase_next = msgtok_pkg::PH_OPER;
                        end
                        msgtok_pkg::ACT_VALUE: begin
                            exec_have       = 1'b1;
                            exec_complete   = 1'b1;
                            tok1_next.kind  = act.kind;
                            tok1_next.value = act.value;
                        end
                        msgtok_pkg::ACT_STR: begin
                            exec_have = 1'b1;
                            if (act.len > bl) begin
                                tok1_next.err = msgtok_pkg::ERR_TRUNC;
                                tok1_next.key = 1'b0;
                                phase_next    = msgtok_pkg::PH_IDLE;
                            end else begin
                                tok1_next.kind  = msgtok_pkg::TK_STRHDR;
                                tok1_next.value = {32'd0, act.len};
                                if (act.len == '0) begin
                                    exec_complete = 1'b1;
                                end else begin
                                    str_left_next = act.len;
                                    phase_next    = msgtok_pkg::PH_STR;
                                end
                            end
                        end
                        msgtok_pkg::ACT_CONT: begin
                            exec_have = 1'b1;
                            if (act.is_map ? (act.len > (bl >> 1)) : (act.len > bl)) begin
                                tok1_next.err = msgtok_pkg::ERR_LEN;
                                tok1_next.key = 1'b0;
                                phase_next    = msgtok_pkg::PH_IDLE;
                            end else if (act.len != '0 && level_reg == LW'(MAX_NESTING)) begin
                                tok1_next.err = msgtok_pkg::ERR_DEEP;
                                tok1_next.key = 1'b0;
                                phase_next    = msgtok_pkg::PH_IDLE;
                            end else begin
                                tok1_next.kind  = act.is_map ? msgtok_pkg::TK_MAP
                                                             : msgtok_pkg::TK_ARRAY;
                                tok1_next.value = {32'd0, act.len};
                                if (act.len == '0) begin
                                    exec_complete = 1'b1;
                                end else begin
                                    push_we      = (level_reg != '0);
                                    top_rem_next = act.is_map ? {act.len, 1'b0}
                                                              : {1'b0, act.len};
                                    top_map_next = act.is_map;
                                    level_next   = level_reg + LW'(1);
                                    phase_next   = msgtok_pkg::PH_TAG;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                tcnt_next = {1'b0, exec_have};
            end
            msgtok_pkg::SQ_POP: begin
                tok2_next.kind  = msgtok_pkg::TK_ERROR;
                tok2_next.value = '0;
                tok2_next.depth = depth_now;
                tok2_next.key   = 1'b0;
                tok2_next.err   = msgtok_pkg::ERR_NONE;
                if (level_reg != '0) begin
                    top_rem_next = pop_dec;
                    if (pop_dec == '0) begin
                        level_next = level_reg - LW'(1);
                    end
                end
                if (pop_done) begin
                    if (level_reg == '0) begin
                        tcnt_next  = 2'd2;
                        phase_next = msgtok_pkg::PH_IDLE;
                        if (body_left_reg == '0) begin
                            tok2_next.kind = msgtok_pkg::TK_END;
                        end else begin
                            tok2_next.err = msgtok_pkg::ERR_TRAIL;
                        end
                    end else if (body_left_reg == '0) begin
                        tcnt_next     = 2'd2;
                        tok2_next.err = msgtok_pkg::ERR_TRUNC;
                        phase_next    = msgtok_pkg::PH_IDLE;
                    end else begin
                        phase_next = msgtok_pkg::PH_TAG;
                    end
                end
            end
            msgtok_pkg::SQ_POPW: begin
                top_rem_next = rd_data_reg[RW-1:0];
                top_map_next = rd_data_reg[RW];
            end
            msgtok_pkg::SQ_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, tok1_reg.err, tok1_reg.key, tok1_reg.depth,
                                     tok1_reg.value, tok1_reg.kind};
                    m_tlast_next  = (tcnt_reg == 2'd1);
                    tok1_next     = tok2_reg;
                    tcnt_next     = tcnt_reg - 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        seq_next = seq_reg;
        case (seq_reg)
            msgtok_pkg::SQ_IDLE: begin
                if (s_tvalid) begin
                    seq_next = msgtok_pkg::SQ_EXEC;
                end
            end
            msgtok_pkg::SQ_EXEC: begin
                if (exec_complete) begin
                    seq_next = msgtok_pkg::SQ_POP;
                end else if (exec_have) begin
                    seq_next = msgtok_pkg::SQ_EMIT;
                end else begin
                    seq_next = msgtok_pkg::SQ_IDLE;
                end
            end
            msgtok_pkg::SQ_POP: begin
                if (pop_done) begin
                    seq_next = msgtok_pkg::SQ_EMIT;
                end else if (pop_to_read) begin
                    seq_next = msgtok_pkg::SQ_POPW;
                end
            end
            msgtok_pkg::SQ_POPW: seq_next = msgtok_pkg::SQ_POP;
            msgtok_pkg::SQ_EMIT: begin
                if (out_free && tcnt_reg == 2'd1) begin
                    seq_next = msgtok_pkg::SQ_IDLE;
                end
            end
            default: seq_next = msgtok_pkg::SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push_we) begin
            stack_mem[wr_idx] <= {top_map_reg, top_rem_reg};
        end
        rd_data_reg <= stack_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= msgtok_pkg::SQ_IDLE;
            phase_reg     <= msgtok_pkg::PH_IDLE;
            level_reg     <= '0;
            tcnt_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            body_left_reg <= '0;
            str_left_reg  <= '0;
            left_reg      <= '0;
            accum_reg     <= '0;
            tag_reg       <= '0;
        end else begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            tcnt_reg      <= tcnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            body_left_reg <= body_left_next;
            str_left_reg  <= str_left_next;
            left_reg      <= left_next;
            accum_reg     <= accum_next;
            tag_reg       <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_rem_reg <= top_rem_next;
        top_map_reg <= top_map_next;
        tok1_reg    <= tok1_next;
        tok2_reg    <= tok2_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_len_reg  <= s_tdata[39:8];
        end
    end

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LW'(MAX_NESTING))
        else $error("nesting level above limit");

    a_popw_level: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == msgtok_pkg::SQ_POPW |-> level_reg != '0 && $past(seq_reg) == msgtok_pkg::SQ_POP)
        else $error("stack read without an open level");

    a_end_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] == msgtok_pkg::TK_END |-> m_tlast && m_tdata[72:68] == '0)
        else $error("end token not last or not at depth zero");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] == msgtok_pkg::TK_ERROR |-> m_tlast && m_tdata[76:74] != '0)
        else $error("error token malformed");
`endif

endmodule

// ===== hdl/msgtok_decode.sv =====
// ----------------------------------------------------------------------------
// MessagePack tag and operand decoder
// Turns a tag byte, or a finished operand, into one parser action.
// ----------------------------------------------------------------------------
module msgtok_decode (
    input  msgtok_pkg::phase_t     phase,
    input  logic [7:0]             data_byte,
    input  logic [7:0]             tag_held,
    input  logic [63:0]            operand,
    input  logic [31:0]            body_rem,
    input  logic                   key_pos,
    output msgtok_pkg::act_t       act
);

    logic [msgtok_pkg::OPN_W:0] nb;

    always_comb begin
        act = '0;
        act.code = msgtok_pkg::ACT_NONE;
        act.kind = msgtok_pkg::TK_NIL;
        act.err = msgtok_pkg::ERR_NONE;
        nb = msgtok_pkg::operand_bytes(data_byte);
        if (phase == msgtok_pkg::PH_TAG) begin
            if (nb[msgtok_pkg::OPN_W]) begin
                act.code = msgtok_pkg::ACT_FAIL;
                act.err = msgtok_pkg::ERR_TAG;
            end else if (nb != '0 && body_rem < 32'(nb)) begin
                act.code = msgtok_pkg::ACT_FAIL;
                act.err = msgtok_pkg::ERR_TRUNC;
            end else if (key_pos && !msgtok_pkg::is_string_tag(data_byte)) begin
                act.code = msgtok_pkg::ACT_FAIL;
                act.err = msgtok_pkg::ERR_KEY;
            end else if (nb != '0) begin
                act.code = msgtok_pkg::ACT_LOAD;
                act.nbytes = nb[msgtok_pkg::OPN_W-1:0];
            end else if (data_byte <= msgtok_pkg::TAG_POSMAX) begin
                act.code = msgtok_pkg::ACT_VALUE;
                act.kind = msgtok_pkg::TK_UINT;
                act.value = {56'd0, data_byte};
            end else if (data_byte[7:4] == 4'h8 || data_byte[7:4] == 4'h9) begin
                act.code = msgtok_pkg::ACT_CONT;
                act.is_map = (data_byte[7:4] == 4'h8);
                act.len = {28'd0, data_byte[3:0]};
            end else if (data_byte[7:5] == 3'b101) begin
                act.code = msgtok_pkg::ACT_STR;
                act.len = {27'd0, data_byte[4:0]};
            end else if (data_byte >= msgtok_pkg::TAG_NEGMIN) begin
                act.code = msgtok_pkg::ACT_VALUE;
                act.kind = msgtok_pkg::TK_INT;
                act.value = {{56{data_byte[7]}}, data_byte};
            end else if (data_byte == msgtok_pkg::TAG_NIL) begin
                act.code = msgtok_pkg::ACT_VALUE;
                act.kind = msgtok_pkg::TK_NIL;
            end else begin
                act.code = msgtok_pkg::ACT_VALUE;
                act.kind = msgtok_pkg::TK_BOOL;
                act.value = {63'd0, data_byte == msgtok_pkg::TAG_TRUE};
            end
        end else begin
            act.code = msgtok_pkg::ACT_VALUE;
            act.value = operand;
            act.len = operand[31:0];
            case (tag_held) inside
                msgtok_pkg::TAG_F32: begin
                    act.kind = msgtok_pkg::TK_F32;
                    act.value = {32'd0, operand[31:0]};
                end
                msgtok_pkg::TAG_F64: act.kind = msgtok_pkg::TK_F64;
                [msgtok_pkg::TAG_U8:msgtok_pkg::TAG_U64]: act.kind = msgtok_pkg::TK_UINT;
                msgtok_pkg::TAG_I8: begin
                    act.kind = msgtok_pkg::TK_INT;
                    act.value = {{56{operand[7]}}, operand[7:0]};
                end
                msgtok_pkg::TAG_I16: begin
                    act.kind = msgtok_pkg::TK_INT;
                    act.value = {{48{operand[15]}}, operand[15:0]};
                end
                msgtok_pkg::TAG_I32: begin
                    act.kind = msgtok_pkg::TK_INT;
                    act.value = {{32{operand[31]}}, operand[31:0]};
                end
                msgtok_pkg::TAG_I64: act.kind = msgtok_pkg::TK_INT;
                [msgtok_pkg::TAG_STR8:msgtok_pkg::TAG_STR32]: act.code = msgtok_pkg::ACT_STR;
                msgtok_pkg::TAG_ARR16, msgtok_pkg::TAG_ARR32: begin
                    act.code = msgtok_pkg::ACT_CONT;
                    act.is_map = 1'b0;
                end
                msgtok_pkg::TAG_MAP16, msgtok_pkg::TAG_MAP32: begin
                    act.code = msgtok_pkg::ACT_CONT;
                    act.is_map = 1'b1;
                end
                default: begin
                    act.code = msgtok_pkg::ACT_FAIL;
                    act.err = msgtok_pkg::ERR_TAG;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// MessagePack stream tokenizer testbench
// Drives start and body words, predicts the token stream in a scoreboard and
// compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        msgtok_pkg::tkind_t kind;
        logic [63:0]        value;
        logic [4:0]         depth;
        logic               key;
        msgtok_pkg::err_t   err;
        logic               last;
    } token_t;

    class token_board;
        token_t              pending[$];
        int                  fails;
        logic [32:0]         lvl_rem[msgtok_pkg::MAX_NESTING_DEF+1];
        logic                lvl_map[msgtok_pkg::MAX_NESTING_DEF+1];
        int unsigned         lvl;
        msgtok_pkg::phase_t  phase;
        logic [7:0]          cur_tag;
        logic [63:0]         accum;
        int unsigned         oper_left;
        logic [31:0]         str_left;
        logic [31:0]         body_left;
        token_t              outq[$];

        function new();
            fails = 0;
            lvl = 0;
            phase = msgtok_pkg::PH_IDLE;
            body_left = 0;
        endfunction

        function void put(msgtok_pkg::tkind_t k, logic [63:0] v, logic [4:0] d, logic ky,
                          msgtok_pkg::err_t e);
            token_t t;
            if (outq.size() >= 2) return;
            t.kind = k; t.value = v; t.depth = d; t.key = ky; t.err = e; t.last = 0;
            outq.insert(outq.size(), t);
        endfunction

        function void fault(msgtok_pkg::err_t e);
            put(msgtok_pkg::TK_ERROR, '0, lvl[4:0], 1'b0, e);
            phase = msgtok_pkg::PH_IDLE;
        endfunction

        function logic key_pos();
            if (lvl == 0 || lvl > msgtok_pkg::MAX_NESTING_DEF) return 0;
            return lvl_map[lvl-1] && !lvl_rem[lvl-1][0];
        endfunction

        function void close_value();
            while (lvl > 0 && lvl <= msgtok_pkg::MAX_NESTING_DEF) begin
                if (lvl_rem[lvl-1] > 0) lvl_rem[lvl-1]--;
                if (lvl_rem[lvl-1] != 0) break;
                lvl--;
            end
            if (lvl == 0) begin
                if (body_left == 0) begin
                    put(msgtok_pkg::TK_END, '0, 5'd0, 1'b0, msgtok_pkg::ERR_NONE);
                    phase = msgtok_pkg::PH_IDLE;
                end else begin
                    fault(msgtok_pkg::ERR_TRAIL);
                end
            end else if (body_left == 0) begin
                fault(msgtok_pkg::ERR_TRUNC);
            end else begin
                phase = msgtok_pkg::PH_TAG;
            end
        endfunction

        function void scalar(msgtok_pkg::tkind_t k, logic [63:0] v);
            put(k, v, lvl[4:0], key_pos(), msgtok_pkg::ERR_NONE);
            close_value();
        endfunction

        function void open_str(logic [31:0] len);
            if (len > body_left) begin
                fault(msgtok_pkg::ERR_TRUNC);
                return;
            end
            put(msgtok_pkg::TK_STRHDR, {32'd0, len}, lvl[4:0], key_pos(),
                msgtok_pkg::ERR_NONE);
            if (len == 0) begin
                close_value();
            end else begin
                str_left = len;
                phase = msgtok_pkg::PH_STR;
            end
        endfunction

        function void open_cont(logic is_map, logic [31:0] len);
            logic [31:0] lim;
            lim = is_map ? body_left / 2 : body_left;
            if (len > lim) begin
                fault(msgtok_pkg::ERR_LEN);
                return;
            end
            if (len != 0 && lvl + 1 > msgtok_pkg::MAX_NESTING_DEF) begin
                fault(msgtok_pkg::ERR_DEEP);
                return;
            end
            put(is_map ? msgtok_pkg::TK_MAP : msgtok_pkg::TK_ARRAY, {32'd0, len}, lvl[4:0],
                key_pos(), msgtok_pkg::ERR_NONE);
            if (len == 0) begin
                close_value();
                return;
            end
            lvl_rem[lvl] = is_map ? {len, 1'b0} : {1'b0, len};
            lvl_map[lvl] = is_map;
            lvl++;
            phase = msgtok_pkg::PH_TAG;
        endfunction

        function void on_tag(logic [7:0] tag);
            logic [4:0] ob;
            ob = msgtok_pkg::operand_bytes(tag);
            if (ob[4]) begin
                fault(msgtok_pkg::ERR_TAG);
                return;
            end
            if (ob != 0 && body_left < ob) begin
                fault(msgtok_pkg::ERR_TRUNC);
                return;
            end
            if (key_pos() && !msgtok_pkg::is_string_tag(tag)) begin
                fault(msgtok_pkg::ERR_KEY);
                return;
            end
            if (ob != 0) begin
                cur_tag = tag;
                accum = 0;
                oper_left = ob;
                phase = msgtok_pkg::PH_OPER;
            end else if (tag <= msgtok_pkg::TAG_POSMAX) scalar(msgtok_pkg::TK_UINT, {56'd0, tag});
            else if (tag[7:4] == 4'h8) open_cont(1'b1, {28'd0, tag[3:0]});
            else if (tag[7:4] == 4'h9) open_cont(1'b0, {28'd0, tag[3:0]});
            else if (tag[7:5] == 3'b101) open_str({27'd0, tag[4:0]});
            else if (tag >= msgtok_pkg::TAG_NEGMIN) scalar(msgtok_pkg::TK_INT, {{56{1'b1}}, tag});
            else if (tag == msgtok_pkg::TAG_NIL) scalar(msgtok_pkg::TK_NIL, '0);
            else scalar(msgtok_pkg::TK_BOOL, {63'd0, tag == msgtok_pkg::TAG_TRUE});
        endfunction

        function void on_operand();
            logic [63:0] v;
            v = accum;
            case (cur_tag)
                msgtok_pkg::TAG_F32: scalar(msgtok_pkg::TK_F32, {32'd0, v[31:0]});
                msgtok_pkg::TAG_F64: scalar(msgtok_pkg::TK_F64, v);
                msgtok_pkg::TAG_U8, msgtok_pkg::TAG_U16, msgtok_pkg::TAG_U32,
                msgtok_pkg::TAG_U64: scalar(msgtok_pkg::TK_UINT, v);
                msgtok_pkg::TAG_I8: scalar(msgtok_pkg::TK_INT, {{56{v[7]}}, v[7:0]});
                msgtok_pkg::TAG_I16: scalar(msgtok_pkg::TK_INT, {{48{v[15]}}, v[15:0]});
                msgtok_pkg::TAG_I32: scalar(msgtok_pkg::TK_INT, {{32{v[31]}}, v[31:0]});
                msgtok_pkg::TAG_I64: scalar(msgtok_pkg::TK_INT, v);
                msgtok_pkg::TAG_STR8, msgtok_pkg::TAG_STR16,
                msgtok_pkg::TAG_STR32: open_str(v[31:0]);
                msgtok_pkg::TAG_ARR16, msgtok_pkg::TAG_ARR32: open_cont(1'b0, v[31:0]);
                msgtok_pkg::TAG_MAP16, msgtok_pkg::TAG_MAP32: open_cont(1'b1, v[31:0]);
                default: fault(msgtok_pkg::ERR_TAG);
            endcase
        endfunction

        function void note_word(logic kind, logic [7:0] b, logic [31:0] blen);
            outq.delete();
            if (!kind) begin
                lvl = 0;
                phase = msgtok_pkg::PH_IDLE;
                body_left = blen;
                if (blen == 0) fault(msgtok_pkg::ERR_TRUNC);
                else phase = msgtok_pkg::PH_TAG;
            end else if (phase != msgtok_pkg::PH_IDLE) begin
                if (body_left > 0) body_left--;
                case (phase)
                    msgtok_pkg::PH_TAG: on_tag(b);
                    msgtok_pkg::PH_OPER: begin
                        accum = (accum << 8) | {56'd0, b};
                        if (oper_left > 0) oper_left--;
                        if (oper_left == 0) on_operand();
                    end
                    msgtok_pkg::PH_STR: begin
                        put(msgtok_pkg::TK_STRBYTE, {56'd0, b}, lvl[4:0], 1'b0,
                            msgtok_pkg::ERR_NONE);
                        if (str_left > 0) str_left--;
                        if (str_left == 0) close_value();
                    end
                    default: phase = msgtok_pkg::PH_IDLE;
                endcase
            end
            if (outq.size() > 0) outq[outq.size()-1].last = 1;
            foreach (outq[i]) pending.insert(pending.size(), outq[i]);
        endfunction

        function void check_token(logic [79:0] d, logic lst);
            token_t e;
            if (pending.size() == 0) begin
                $error("unexpected token word %h", d);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (d[3:0] !== e.kind) begin
                $error("token_kind exp %0d got %0d", e.kind, d[3:0]); fails++;
            end
            if (d[67:4] !== e.value) begin
                $error("token_value exp %h got %h", e.value, d[67:4]); fails++;
            end
            if (d[72:68] !== e.depth) begin
                $error("token_depth exp %0d got %0d", e.depth, d[72:68]); fails++;
            end
            if (d[73] !== e.key) begin
                $error("is_map_key exp %0d got %0d", e.key, d[73]); fails++;
            end
            if (d[76:74] !== e.err) begin
                $error("error_code exp %0d got %0d", e.err, d[76:74]); fails++;
            end
            if (lst !== e.last) begin
                $error("last_of_run exp %0d got %0d", e.last, lst); fails++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;

    token_board board;
    bit          calm;
    bit          hold_off;
    bit          held;
    logic [7:0]  doc[$];

    msgpack_stream_tokenizer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_token(m_tdata, m_tlast);
    end

    initial begin
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_tready <= 1;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(logic kind, logic [7:0] b, logic [31:0] blen);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {blen, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_word(kind, b, blen);
        @(negedge aclk);
    endtask

    task automatic add_byte(logic [7:0] v);
        doc.insert(doc.size(), v);
    endtask

    task automatic send_doc(logic [31:0] blen);
        send_word(1'b0, 8'($urandom), blen);
        foreach (doc[i]) send_word(1'b1, doc[i], $urandom);
        doc.delete();
    endtask

    task automatic push_bytes(logic [63:0] v, int nb);
        for (int i = nb - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
    endtask

    // Builds one random value into doc; containers deeper than level six are left empty.
    task automatic gen_value(int depth, bit as_key);
        int sel;
        int cnt;
        sel = as_key ? 4 : $urandom_range(0, 9);
        case (sel)
            0: add_byte(8'($urandom_range(0, 127)));
            1: add_byte(8'($urandom_range(224, 255)));
            2: add_byte(8'hc0 + 8'($urandom_range(0, 3)));
            3: begin
                int t;
                t = $urandom_range(0, 9);
                case (t)
                    0: begin add_byte(msgtok_pkg::TAG_U8);  push_bytes({$urandom, $urandom}, 1); end
                    1: begin add_byte(msgtok_pkg::TAG_U16); push_bytes({$urandom, $urandom}, 2); end
                    2: begin add_byte(msgtok_pkg::TAG_U32); push_bytes({$urandom, $urandom}, 4); end
                    3: begin add_byte(msgtok_pkg::TAG_U64); push_bytes({$urandom, $urandom}, 8); end
                    4: begin add_byte(msgtok_pkg::TAG_I8);  push_bytes({$urandom, $urandom}, 1); end
                    5: begin add_byte(msgtok_pkg::TAG_I16); push_bytes({$urandom, $urandom}, 2); end
                    6: begin add_byte(msgtok_pkg::TAG_I32); push_bytes({$urandom, $urandom}, 4); end
                    7: begin add_byte(msgtok_pkg::TAG_I64); push_bytes({$urandom, $urandom}, 8); end
                    8: begin add_byte(msgtok_pkg::TAG_F32); push_bytes({$urandom, $urandom}, 4); end
                    default: begin
                        add_byte(msgtok_pkg::TAG_F64); push_bytes({$urandom, $urandom}, 8);
                    end
                endcase
            end
            4: begin
                cnt = $urandom_range(0, 4);
                case ($urandom_range(0, 3))
                    0: add_byte(8'ha0 | {3'd0, cnt[4:0]});
                    1: begin add_byte(msgtok_pkg::TAG_STR8); push_bytes(64'(cnt), 1); end
                    2: begin add_byte(msgtok_pkg::TAG_STR16); push_bytes(64'(cnt), 2); end
                    default: begin add_byte(msgtok_pkg::TAG_STR32); push_bytes(64'(cnt), 4); end
                endcase
                repeat (cnt) add_byte(8'($urandom));
            end
            5, 6, 7: begin
                cnt = (depth > 6) ? 0 : $urandom_range(0, 3);
                if (depth < 3 && $urandom_range(0, 1)) begin
                    add_byte(8'h90 | {4'd0, cnt[3:0]});
                end else begin
                    case ($urandom_range(0, 1))
                        0: begin add_byte(msgtok_pkg::TAG_ARR16); push_bytes(64'(cnt), 2); end
                        default: begin
                            add_byte(msgtok_pkg::TAG_ARR32); push_bytes(64'(cnt), 4);
                        end
                    endcase
                end
                repeat (cnt) gen_value(depth + 1, 0);
            end
            default: begin
                cnt = (depth > 6) ? 0 : $urandom_range(0, 3);
                case ($urandom_range(0, 2))
                    0: add_byte(8'h80 | {4'd0, cnt[3:0]});
                    1: begin add_byte(msgtok_pkg::TAG_MAP16); push_bytes(64'(cnt), 2); end
                    default: begin add_byte(msgtok_pkg::TAG_MAP32); push_bytes(64'(cnt), 4); end
                endcase
                repeat (cnt) begin
                    gen_value(depth + 1, $urandom_range(0, 9) != 0);
                    gen_value(depth + 1, 0);
                end
            end
        endcase
    endtask

    initial begin
        int words;
        int n;
        int wait_cyc;
        board = new();
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = 0;
        calm = 0;
        hold_off = 0;
        held = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Bytes before any start are ignored.
        send_word(1'b1, 8'hff, 32'hffffffff);
        send_word(1'b0, 8'h00, 32'd0);
        // Scalars at the field extremes, then bad tag, truncation, length, key and trailing errors.
        doc = '{8'h00}; send_doc(1);
        doc = '{8'hff}; send_doc(1);
        doc = '{8'h7f}; send_doc(2);
        doc = '{msgtok_pkg::TAG_U64, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_doc(9);
        doc = '{msgtok_pkg::TAG_I64, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_doc(9);
        doc = '{8'hc1}; send_doc(1);
        doc = '{msgtok_pkg::TAG_U32, 8'h01}; send_doc(3);
        doc = '{8'h81, 8'h01, 8'h02}; send_doc(3);
        doc = '{8'h92, 8'h01}; send_doc(2);
        doc = '{8'h93, 8'hc0}; send_doc(2);
        doc = '{8'ha3, 8'h41}; send_doc(2);
        doc = '{8'h81, 8'ha1, 8'h6b, 8'hc3}; send_doc(4);
        // Restart in the middle of a document.
        doc = '{8'h92, 8'h01}; send_doc(3);
        // Nesting one level too deep, then exactly at the limit.
        for (int i = 0; i < 17; i++) add_byte(8'h91);
        add_byte(8'hc2);
        send_doc(18);
        for (int i = 0; i < 16; i++) add_byte(8'h91);
        add_byte(8'hc2);
        send_doc(32'hffffffff);
        send_word(1'b1, 8'h00, 32'd0);
        words = 60;

        while (words < 1000 || board.pending.size() > 0 && words < 1100) begin
            gen_value(0, 0);
            n = doc.size();
            case ($urandom_range(0, 9))
                0: send_doc(n + $urandom_range(1, 3));
                1: begin
                    if (n > 1) send_doc($urandom_range(1, n - 1)); else send_doc(n);
                end
                2: begin
                    doc[$urandom_range(0, n - 1)] = 8'($urandom);
                    send_doc(n);
                end
                default: send_doc(n);
            endcase
            words += n + 1;
            if (words > 400 && !held) begin
                held = 1;
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(posedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            if (words > 850) calm = 1;
        end
        s_tvalid <= 0;

        wait_cyc = 0;
        while (board.pending.size() > 0 && wait_cyc < 100000) begin
            @(posedge aclk);
            wait_cyc++;
        end
        repeat (50) @(posedge aclk);
        if (board.fails == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (board.pending.size() > 0) $error("tokens never arrived: %0d", board.pending.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
